@@ sv/tstf_pkg.sv @@
package tstf_pkg;

    // Largest run and window the datapath is sized for.
    localparam int MAX_LENGTH = 65536;
    localparam int MAX_WINDOW = 1024;

    // Fixed field and register widths.
    localparam int SAMPLE_W = 16;
    localparam int END_W    = 17;
    localparam int CFG_LEN_W   = 17;
    localparam int CFG_WIN_W   = 11;
    localparam int CFG_LEVEL_W = 15;
    localparam int CFG_DATA_W  = 17;
    localparam int CFG_IDX_W   = 2;

    // Derived datapath widths.
    localparam int LEN_W  = $clog2(MAX_LENGTH + 1);
    localparam int POS_W  = $clog2(MAX_LENGTH);
    localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
    localparam int FILL_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int MAG_W  = SAMPLE_W + 1;
    localparam int MAG_MAX = 32768;
    localparam int SUM_W  = $clog2(MAX_WINDOW * MAG_MAX + 1);
    localparam int CNT_W  = $clog2(LEN_W + 1);

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THRESHOLD = 2'd2;

    // Register reset values.
    localparam logic [CFG_LEN_W-1:0]   RST_SAMPLE_LENGTH   = 17'd65536;
    localparam logic [CFG_WIN_W-1:0]   RST_WINDOW_LENGTH   = 11'd100;
    localparam logic [CFG_LEVEL_W-1:0] RST_LEVEL_THRESHOLD = 15'd983;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_DIV,
        ST_FIN,
        ST_RUN
    } t_state;

endpackage

@@ sv/trailing_silence_trim_finder.sv @@
// Trailing silence trim finder.
//
// Samples arrive on the slave stream, one signed 16-bit sample per request.
// A run of sample_length samples is cut into windows of window_length
// samples, aligned so that the last window ends on the last sample. Windows
// starting at index 0 or in a leading partial chunk are ignored. On the last
// sample of a run the master stream carries one request: the end index of
// the latest window whose absolute-sum exceeds level_threshold * window_length,
// or 0 when no window is loud. Other samples produce nothing.
//
// Throughput is one sample per cycle while tready is high: the absolute value,
// window sum and threshold compare all happen between the run state registers.
// The result is valid on the master side in the cycle after the last sample.
//
// After reset and after every configuration write the block steps through
// load, 17 remainder steps and finish to compute where the first judged window
// starts, with tready low; this remainder unit is a bit-serial divider.
// A configuration write restarts the run. When the receiver stalls, the result
// holds in the output register; further samples are still taken until the
// last sample of the next run would need that register.
module trailing_silence_trim_finder (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Slave stream: tdata[15:0] = sample
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [15:0]                           i_s_axis_tdata,
    // Master stream: tdata[16:0] = end_index, tdata[23:17] = zero
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    output logic [23:0]                           o_m_axis_tdata,
    // Configuration write port
    input  logic                                  i_cfg_we,
    input  logic [tstf_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [tstf_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import tstf_pkg::*;

    // Configuration registers.
    logic [CFG_LEN_W-1:0]   r_cfg_len;
    logic [CFG_WIN_W-1:0]   r_cfg_win;
    logic [CFG_LEVEL_W-1:0] r_cfg_level;

    // Setup sequencer and remainder unit.
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [LEN_W-1:0]   r_dvd;
    logic [WIN_W-1:0]   r_rem;

    // Values derived once per configuration.
    logic [WIN_W-1:0]   r_first_start;
    logic [SUM_W-1:0]   r_limit;
    logic [FILL_W-1:0]  r_win_m1;
    logic [POS_W-1:0]   r_last_pos;

    // Run state.
    logic [POS_W-1:0]   r_pos;
    logic [FILL_W-1:0]  r_fill;
    logic [SUM_W-1:0]   r_sum;
    logic [LEN_W-1:0]   r_found;

    // Output register.
    logic               r_out_valid;
    logic [LEN_W-1:0]   r_out_end;

    logic [LEN_W-1:0]   eff_len;
    logic [WIN_W-1:0]   eff_win;
    logic               cfg_hit;
    logic [WIN_W:0]     trial;
    logic               s_accept;
    logic               is_last;
    logic               judging;
    logic [MAG_W-1:0]   mag;
    logic [SUM_W-1:0]   sum_n;
    logic [LEN_W-1:0]   found_n;

    // Clamp the raw registers to the supported ranges.
    always_comb begin
        if (r_cfg_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (32'(r_cfg_len) > MAX_LENGTH) begin
            eff_len = LEN_W'(MAX_LENGTH);
        end else begin
            eff_len = LEN_W'(r_cfg_len);
        end
        if (r_cfg_win == '0) begin
            eff_win = WIN_W'(1);
        end else if (32'(r_cfg_win) > MAX_WINDOW) begin
            eff_win = WIN_W'(MAX_WINDOW);
        end else begin
            eff_win = WIN_W'(r_cfg_win);
        end
    end

    assign cfg_hit = i_cfg_we && (i_cfg_index == CFG_SAMPLE_LENGTH ||
                                  i_cfg_index == CFG_WINDOW_LENGTH ||
                                  i_cfg_index == CFG_LEVEL_THRESHOLD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len   <= RST_SAMPLE_LENGTH;
            r_cfg_win   <= RST_WINDOW_LENGTH;
            r_cfg_level <= RST_LEVEL_THRESHOLD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SAMPLE_LENGTH:   r_cfg_len   <= i_cfg_data[CFG_LEN_W-1:0];
                CFG_WINDOW_LENGTH:   r_cfg_win   <= i_cfg_data[CFG_WIN_W-1:0];
                CFG_LEVEL_THRESHOLD: r_cfg_level <= i_cfg_data[CFG_LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer: after reset or a write, compute the run length modulo the
    // window length one dividend bit per cycle, then derive the constants.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: n_state = ST_DIV;
            ST_DIV:  if (r_cnt == CNT_W'(1)) n_state = ST_FIN;
            ST_FIN:  n_state = ST_RUN;
            ST_RUN:  n_state = ST_RUN;
            default: n_state = ST_LOAD;
        endcase
        if (cfg_hit) begin
            n_state = ST_LOAD;
        end
    end

    assign trial = {r_rem, r_dvd[LEN_W-1]};

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_LOAD: begin
                r_dvd <= eff_len;
                r_rem <= '0;
                r_cnt <= CNT_W'(LEN_W);
            end
            ST_DIV: begin
                r_dvd <= {r_dvd[LEN_W-2:0], 1'b0};
                r_cnt <= r_cnt - CNT_W'(1);
                if (trial >= {1'b0, eff_win}) begin
                    r_rem <= WIN_W'(trial - {1'b0, eff_win});
                end else begin
                    r_rem <= WIN_W'(trial);
                end
            end
            ST_FIN: begin
                // A run no longer than a window, or a whole number of windows,
                // starts judging at one window in.
                if (32'(eff_win) >= 32'(eff_len) || r_rem == '0) begin
                    r_first_start <= eff_win;
                end else begin
                    r_first_start <= r_rem;
                end
                r_limit    <= SUM_W'(r_cfg_level) * SUM_W'(eff_win);
                r_win_m1   <= FILL_W'(eff_win - WIN_W'(1));
                r_last_pos <= POS_W'(eff_len - LEN_W'(1));
            end
            default: begin
            end
        endcase
    end

    // Sample path.
    assign is_last  = (r_pos == r_last_pos);
    assign o_s_axis_tready = (r_state == ST_RUN) && !cfg_hit &&
                             (!r_out_valid || i_m_axis_tready || !is_last);
    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;

    assign mag = i_s_axis_tdata[SAMPLE_W-1] ?
                 (MAG_W'(0) - {1'b1, i_s_axis_tdata}) :
                 {1'b0, i_s_axis_tdata};
    assign judging = (32'(r_pos) >= 32'(r_first_start));
    assign sum_n   = r_sum + SUM_W'(mag);

    always_comb begin
        found_n = r_found;
        if (judging && r_fill == r_win_m1 && sum_n > r_limit) begin
            found_n = LEN_W'(r_pos) + LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_pos   <= '0;
            r_fill  <= '0;
            r_sum   <= '0;
            r_found <= '0;
        end else if (s_accept) begin
            if (is_last) begin
                r_pos   <= '0;
                r_fill  <= '0;
                r_sum   <= '0;
                r_found <= '0;
            end else begin
                r_pos   <= r_pos + POS_W'(1);
                r_found <= found_n;
                if (judging) begin
                    if (r_fill == r_win_m1) begin
                        r_fill <= '0;
                        r_sum  <= '0;
                    end else begin
                        r_fill <= r_fill + FILL_W'(1);
                        r_sum  <= sum_n;
                    end
                end
            end
        end
    end

    // Output register: loaded on the last sample, freed when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_accept && is_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept && is_last) begin
            r_out_end <= found_n;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'b0, END_W'(r_out_end)};

endmodule
